@@ design/uss_pkg.sv @@
// Shared types and constants for the UTF-8 stream sanitizer.
// No dependencies; every other design file refers to this package by scoped names.
package uss_pkg;

  localparam int COUNT_WIDTH = 32;
  localparam int QUEUE_DEPTH = 5;
  localparam int MAX_RESULTS = 4;
  localparam int OUT_WIDTH   = 32;

  localparam logic [7:0] QMARK     = 8'h3F;
  localparam logic [7:0] ASCII_MAX = 8'h7F;
  localparam logic [7:0] BAD_MAX   = 8'hC1;
  localparam logic [7:0] LEAD2_MAX = 8'hDF;
  localparam logic [7:0] LEAD3_MAX = 8'hEF;
  localparam logic [7:0] LEAD4_MAX = 8'hF7;

  localparam logic [20:0] FLOOR2 = 21'h00080;
  localparam logic [20:0] FLOOR3 = 21'h00800;
  localparam logic [20:0] FLOOR4 = 21'h10000;

  localparam logic [2:0] LEN_NONE = 3'd0;
  localparam logic [2:0] LEN_TWO  = 3'd2;
  localparam logic [2:0] LEN_THREE = 3'd3;
  localparam logic [2:0] LEN_FOUR = 3'd4;

  // One queue entry: all results caused by one input byte, in output order.
  typedef struct packed {
    logic [2:0]                   cnt;
    logic                         eos;
    logic [MAX_RESULTS-1:0]       start;
    logic [MAX_RESULTS-1:0][7:0]  bytes;
  } entry_t;

endpackage

@@ design/utf8_stream_sanitizer_top.sv @@
// Top level of the UTF-8 stream sanitizer: front end, entry queue, back end.
// Depends on uss_pkg, uss_front, uss_queue and uss_back.
//
// Sanitizes a byte stream as UTF-8, one byte per transfer on the input and one
// byte per transfer on the output; the output carries exactly as many bytes as
// the input. Valid sequences pass unchanged, and broken, stray, reserved
// or overlong bytes become '?', each its own glyph. Every output byte carries its
// glyph number and byte offset within the string; the last result of the
// end-of-string byte raises string_done and carries the glyph total, and both
// counters then restart from zero. Counters saturate at COUNT_WIDTH bits and
// are reported in their low 32 bits. Rate: one input byte per cycle while the
// entry queue (QUEUE_DEPTH entries) has room, one result per cycle out of the
// back end while result_stall is low. A byte that completes or breaks a
// sequence causes up to four results, which the back end delivers one at a
// time; bytes that only extend a sequence cause none, so a steady stream with
// no result stall runs at one byte per cycle. A byte's first result passes
// through a queue slot and the output register. No clearing pass after reset.
module utf8_stream_sanitizer_top #(
  parameter int COUNT_WIDTH = uss_pkg::COUNT_WIDTH,
  parameter int QUEUE_DEPTH = uss_pkg::QUEUE_DEPTH
) (
  input  logic                          clk,
  input  logic                          rst,
  // Input channel.
  input  logic                          data_valid,
  output logic                          data_stall,
  input  logic [7:0]                    data_byte,
  input  logic                          end_of_string,
  // Result channel.
  output logic                          result_valid,
  input  logic                          result_stall,
  output logic [7:0]                    out_byte,
  output logic                          glyph_start,
  output logic [uss_pkg::OUT_WIDTH-1:0] glyph_number,
  output logic [uss_pkg::OUT_WIDTH-1:0] byte_offset,
  output logic                          run_last,
  output logic                          string_done,
  output logic [uss_pkg::OUT_WIDTH-1:0] glyph_total
);

  uss_pkg::entry_t entry, head;
  logic            take, push, pop, empty, full;

  // Hold the input whenever the queue cannot take another entry.
  assign data_stall = full;
  assign take       = data_valid && !data_stall;

  uss_front u_front (
    .clk           (clk),
    .rst           (rst),
    .take          (take),
    .data_byte     (data_byte),
    .end_of_string (end_of_string),
    .push          (push),
    .entry         (entry)
  );

  uss_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (entry),
    .pop        (pop),
    .head       (head),
    .empty      (empty),
    .full       (full)
  );

  uss_back #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .head         (head),
    .empty        (empty),
    .pop          (pop),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .out_byte     (out_byte),
    .glyph_start  (glyph_start),
    .glyph_number (glyph_number),
    .byte_offset  (byte_offset),
    .run_last     (run_last),
    .string_done  (string_done),
    .glyph_total  (glyph_total)
  );

endmodule

@@ design/uss_front.sv @@
// Front end: accepts bytes, tracks the pending multibyte sequence and
// classifies each byte into one queue entry. Depends on uss_pkg.
module uss_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              take,
  input  logic [7:0]        data_byte,
  input  logic              end_of_string,
  output logic              push,
  output uss_pkg::entry_t   entry
);

  logic [7:0]  pend [3];
  logic [1:0]  pcnt, pcnt_next;
  logic [2:0]  elen, elen_next;
  logic        wr_en;
  logic [1:0]  wr_idx;

  logic        is_cont, pend_act, ascii, overlong;
  logic [2:0]  lead_len;
  logic [1:0]  np;
  logic        pend_q, cur_emit, cur_start;
  logic [7:0]  cur_byte;
  logic [20:0] w, floor_val;

  always_comb begin
    is_cont  = (data_byte[7:6] == 2'b10);
    pend_act = (pcnt != 2'd0);
    ascii    = (data_byte <= uss_pkg::ASCII_MAX);
    if (data_byte <= uss_pkg::BAD_MAX)        lead_len = uss_pkg::LEN_NONE;
    else if (data_byte <= uss_pkg::LEAD2_MAX) lead_len = uss_pkg::LEN_TWO;
    else if (data_byte <= uss_pkg::LEAD3_MAX) lead_len = uss_pkg::LEN_THREE;
    else if (data_byte <= uss_pkg::LEAD4_MAX) lead_len = uss_pkg::LEN_FOUR;
    else                                      lead_len = uss_pkg::LEN_NONE;

    // Decoded code point of a sequence completed by this byte.
    case (elen)
      uss_pkg::LEN_TWO: begin
        w         = {10'd0, pend[0][4:0], data_byte[5:0]};
        floor_val = uss_pkg::FLOOR2;
      end
      uss_pkg::LEN_THREE: begin
        w         = {5'd0, pend[0][3:0], pend[1][5:0], data_byte[5:0]};
        floor_val = uss_pkg::FLOOR3;
      end
      default: begin
        w         = {pend[0][2:0], pend[1][5:0], pend[2][5:0], data_byte[5:0]};
        floor_val = uss_pkg::FLOOR4;
      end
    endcase
    overlong = (w < floor_val);

    np        = 2'd0;
    pend_q    = 1'b1;
    cur_emit  = 1'b0;
    cur_byte  = data_byte;
    cur_start = 1'b1;
    pcnt_next = pcnt;
    elen_next = elen;
    wr_en     = 1'b0;
    wr_idx    = pcnt;

    if (pend_act && is_cont) begin
      if (({1'b0, pcnt} + 3'd1) >= elen) begin
        // Sequence complete: pass through or replace whole.
        np        = pcnt;
        pend_q    = overlong;
        cur_emit  = 1'b1;
        cur_byte  = overlong ? uss_pkg::QMARK : data_byte;
        cur_start = overlong;
        pcnt_next = 2'd0;
        elen_next = uss_pkg::LEN_NONE;
      end else if (end_of_string) begin
        np        = pcnt;
        cur_emit  = 1'b1;
        cur_byte  = uss_pkg::QMARK;
      end else begin
        wr_en     = 1'b1;
        pcnt_next = pcnt + 2'd1;
      end
    end else begin
      // Broken sequence (if any) flushes as '?', then the byte starts afresh.
      np        = pcnt;
      pcnt_next = 2'd0;
      elen_next = uss_pkg::LEN_NONE;
      if (ascii) begin
        cur_emit = 1'b1;
      end else if (lead_len != uss_pkg::LEN_NONE) begin
        if (end_of_string) begin
          cur_emit = 1'b1;
          cur_byte = uss_pkg::QMARK;
        end else begin
          wr_en     = 1'b1;
          wr_idx    = 2'd0;
          pcnt_next = 2'd1;
          elen_next = lead_len;
        end
      end else begin
        cur_emit = 1'b1;
        cur_byte = uss_pkg::QMARK;
      end
    end

    if (end_of_string) begin
      pcnt_next = 2'd0;
      elen_next = uss_pkg::LEN_NONE;
    end

    entry.cnt = {1'b0, np} + {2'd0, cur_emit};
    entry.eos = end_of_string;
    for (int i = 0; i < uss_pkg::MAX_RESULTS; i++) begin
      entry.bytes[i] = cur_byte;
      entry.start[i] = cur_start;
    end
    for (int i = 0; i < 3; i++) begin
      if (np > 2'(i)) begin
        entry.bytes[i] = pend_q ? uss_pkg::QMARK : pend[i];
        entry.start[i] = pend_q || (i == 0);
      end
    end

    push = take && (entry.cnt != 3'd0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pcnt <= 2'd0;
      elen <= uss_pkg::LEN_NONE;
    end else if (take) begin
      pcnt <= pcnt_next;
      elen <= elen_next;
    end
  end

  always_ff @(posedge clk) begin
    if (take && wr_en) begin
      pend[wr_idx] <= data_byte;
    end
  end

`ifndef SYNTHESIS
  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    push |-> entry.cnt <= 3'(uss_pkg::MAX_RESULTS))
    else $error("front: entry carries more than four results");
  a_eos_emits: assert property (@(posedge clk) disable iff (rst)
    (take && end_of_string) |-> push)
    else $error("front: end of string produced no result");
`endif

endmodule

@@ design/uss_queue.sv @@
// Short entry queue between the front and back ends.
// Depends on uss_pkg for the entry type.
module uss_queue #(
  parameter int DEPTH = uss_pkg::QUEUE_DEPTH
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  uss_pkg::entry_t   push_entry,
  input  logic              pop,
  output uss_pkg::entry_t   head,
  output logic              empty,
  output logic              full
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  uss_pkg::entry_t slots [DEPTH];
  logic [PW-1:0]   wr_ptr, rd_ptr;
  logic [CW-1:0]   count;

  assign empty = (count == CW'(0));
  assign full  = (count == CW'(DEPTH));
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> (!full || pop))
    else $error("queue: push while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> !empty)
    else $error("queue: pop while empty");
`endif

endmodule

@@ design/uss_back.sv @@
// Back end: walks the head entry one result per unstalled cycle, numbers glyphs and
// bytes with saturating counters, and holds the output register. Depends on uss_pkg.
module uss_back #(
  parameter int COUNT_WIDTH = uss_pkg::COUNT_WIDTH
) (
  input  logic                             clk,
  input  logic                             rst,
  input  uss_pkg::entry_t                  head,
  input  logic                             empty,
  output logic                             pop,
  output logic                             result_valid,
  input  logic                             result_stall,
  output logic [7:0]                       out_byte,
  output logic                             glyph_start,
  output logic [uss_pkg::OUT_WIDTH-1:0]    glyph_number,
  output logic [uss_pkg::OUT_WIDTH-1:0]    byte_offset,
  output logic                             run_last,
  output logic                             string_done,
  output logic [uss_pkg::OUT_WIDTH-1:0]    glyph_total
);

  logic [COUNT_WIDTH-1:0] glyph_cnt, glyph_cnt_next;
  logic [COUNT_WIDTH-1:0] byte_cnt, byte_cnt_next;
  logic [COUNT_WIDTH-1:0] cur_glyph, glyph_inc, byte_inc, num_val;
  logic [1:0]             idx;
  logic                   load, st, last, done;

  always_comb begin
    load      = !empty && (!result_valid || !result_stall);
    st        = head.start[idx];
    last      = ({1'b0, idx} == (head.cnt - 3'd1));
    done      = last && head.eos;
    glyph_inc = (glyph_cnt == '1) ? glyph_cnt : glyph_cnt + COUNT_WIDTH'(1);
    byte_inc  = (byte_cnt == '1) ? byte_cnt : byte_cnt + COUNT_WIDTH'(1);
    num_val   = st ? glyph_cnt : cur_glyph;
    glyph_cnt_next = st ? glyph_inc : glyph_cnt;
    byte_cnt_next  = byte_inc;
    pop       = load && last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      glyph_cnt    <= '0;
      byte_cnt     <= '0;
      idx          <= 2'd0;
      result_valid <= 1'b0;
    end else begin
      if (load) begin
        // Clear both counters after the final result of a string.
        glyph_cnt    <= done ? '0 : glyph_cnt_next;
        byte_cnt     <= done ? '0 : byte_cnt_next;
        idx          <= last ? 2'd0 : idx + 2'd1;
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      if (st) begin
        cur_glyph <= glyph_cnt;
      end
      out_byte     <= head.bytes[idx];
      glyph_start  <= st;
      glyph_number <= uss_pkg::OUT_WIDTH'(num_val);
      byte_offset  <= uss_pkg::OUT_WIDTH'(byte_cnt);
      run_last     <= last;
      string_done  <= done;
      glyph_total  <= done ? uss_pkg::OUT_WIDTH'(glyph_cnt_next) : '0;
    end
  end

`ifndef SYNTHESIS
  a_first_starts: assert property (@(posedge clk) disable iff (rst)
    (load && idx == 2'd0) |-> head.start[0])
    else $error("back: first result of a step does not start a glyph");
  a_done_clears: assert property (@(posedge clk) disable iff (rst)
    (load && done) |=> (byte_cnt == '0 && glyph_cnt == '0 && idx == 2'd0))
    else $error("back: counters not cleared after end of string");
`endif

endmodule
